### rtl/mse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants for the merge sort engine.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned DEPTH_DEFAULT = 64;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;       // input transaction taken
        logic pass_init;  // start a merge pass at run base 0
        logic run_init;   // set up pointers of the next pair of runs
        logic merge;      // one compare / write step
        logic emit_init;  // rewind the read pointer for output
        logic emit;       // load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic w_lt_n;     // run width below element count: another pass
        logic run_last;   // current merge step finishes the run pair
        logic pass_last;  // current run pair is the last of the pass
        logic emit_last;  // current output element is the final one
        logic out_free;   // output register can take a new element
    } t_stat;

endpackage

### rtl/mse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_ctrl
// Sequencer: load, bottom-up merge passes, then emission of the sorted set.
// ----------------------------------------------------------------------------
module mse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    input  mse_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output mse_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS,
        S_RUN,
        S_RD,
        S_MRG,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    t_state        r_state;
    t_state        n_state;
    mse_pkg::t_cmd n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    n_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_state = S_PASS;
                    end
                end
            end
            S_PASS: begin
                if (i_stat.w_lt_n) begin
                    n_cmd.pass_init = 1'b1;
                    n_state         = S_RUN;
                end else begin
                    n_cmd.emit_init = 1'b1;
                    n_state         = S_EMIT_RD;
                end
            end
            S_RUN: begin
                n_cmd.run_init = 1'b1;
                n_state        = S_RD;
            end
            S_RD: begin
                n_state = S_MRG;
            end
            S_MRG: begin
                n_cmd.merge = 1'b1;
                if (i_stat.run_last) begin
                    n_state = i_stat.pass_last ? S_PASS : S_RUN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_cmd.emit = 1'b1;
                    n_state    = i_stat.emit_last ? S_LOAD : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_LOAD);
    assign o_cmd      = n_cmd;

endmodule

### rtl/mse_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_datapath
// Ping-pong buffers, run pointers, comparator and output register.
// ----------------------------------------------------------------------------
module mse_datapath #(
    parameter int unsigned DEPTH = mse_pkg::DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mse_pkg::t_cmd  i_cmd,
    input  mse_pkg::t_in   i_in_data,
    input  logic           i_out_ready,
    output mse_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output mse_pkg::t_out  o_out_data
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // buffers
    logic signed [mse_pkg::DATA_W-1:0] r_mem_a [DEPTH];
    logic signed [mse_pkg::DATA_W-1:0] r_mem_b [DEPTH];
    logic signed [mse_pkg::DATA_W-1:0] r_rd_a0, r_rd_a1, r_rd_b0, r_rd_b1;

    // control counters
    logic [CW-1:0] r_count;
    logic          r_dropped;
    logic [CW:0]   r_w;
    logic          r_src;      // 0: sorted data sits in buffer A
    logic [CW-1:0] r_lo, r_i, r_j, r_k, r_mid, r_hi;
    logic          r_out_valid;
    mse_pkg::t_out r_out;

    logic signed [mse_pkg::DATA_W-1:0] head0, head1, merge_data;
    logic [CW+1:0] sum_mid, sum_hi;
    logic [CW-1:0] run_mid, run_hi;
    logic          take_left, has_room;
    logic          we_a, we_b;
    logic [AW-1:0] addr_a;
    logic signed [mse_pkg::DATA_W-1:0] wdata_a;

    assign has_room = (r_count < CW'(DEPTH));

    assign sum_mid = {2'b00, r_lo} + {1'b0, r_w};
    assign sum_hi  = {2'b00, r_lo} + {r_w, 1'b0};
    assign run_mid = (sum_mid < {2'b00, r_count}) ? sum_mid[CW-1:0] : r_count;
    assign run_hi  = (sum_hi  < {2'b00, r_count}) ? sum_hi[CW-1:0]  : r_count;

    assign head0 = r_src ? r_rd_b0 : r_rd_a0;
    assign head1 = r_src ? r_rd_b1 : r_rd_a1;

    // ties go to the left run, which keeps the sort stable
    assign take_left  = (r_i < r_mid) && ((r_j >= r_hi) || (head0 <= head1));
    assign merge_data = take_left ? head0 : head1;

    assign we_a    = (i_cmd.load && has_room) || (i_cmd.merge && r_src);
    assign we_b    = i_cmd.merge && !r_src;
    assign addr_a  = i_cmd.load ? r_count[AW-1:0] : r_k[AW-1:0];
    assign wdata_a = i_cmd.load ? i_in_data.value : merge_data;

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[addr_a] <= wdata_a;
        end
        if (we_b) begin
            r_mem_b[r_k[AW-1:0]] <= merge_data;
        end
        r_rd_a0 <= r_mem_a[r_i[AW-1:0]];
        r_rd_a1 <= r_mem_a[r_j[AW-1:0]];
        r_rd_b0 <= r_mem_b[r_i[AW-1:0]];
        r_rd_b1 <= r_mem_b[r_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_w         <= '0;
            r_src       <= 1'b0;
            r_lo        <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_mid       <= '0;
            r_hi        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (has_room) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_dropped <= 1'b1;
                end
                if (i_in_data.last) begin
                    r_w   <= (CW+1)'(1);
                    r_src <= 1'b0;
                end
            end
            if (i_cmd.pass_init) begin
                r_lo <= '0;
            end
            if (i_cmd.run_init) begin
                r_i   <= r_lo;
                r_j   <= run_mid;
                r_k   <= r_lo;
                r_mid <= run_mid;
                r_hi  <= run_hi;
            end
            if (i_cmd.merge) begin
                if (take_left) begin
                    r_i <= r_i + CW'(1);
                end else begin
                    r_j <= r_j + CW'(1);
                end
                r_k <= r_k + CW'(1);
                if (o_stat.run_last) begin
                    r_lo <= r_hi;
                    if (o_stat.pass_last) begin
                        r_w   <= {r_w[CW-1:0], 1'b0};
                        r_src <= ~r_src;
                    end
                end
            end
            if (i_cmd.emit_init) begin
                r_i <= '0;
            end
            if (i_cmd.emit) begin
                r_i <= r_i + CW'(1);
                if (o_stat.emit_last) begin
                    r_count   <= '0;
                    r_dropped <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.sorted_value <= head0;
            r_out.last_out     <= o_stat.emit_last;
            r_out.overflow     <= r_dropped;
        end
    end

    assign o_stat.w_lt_n    = (r_w < {1'b0, r_count});
    assign o_stat.run_last  = ((r_k + CW'(1)) == r_hi);
    assign o_stat.pass_last = (r_hi == r_count);
    assign o_stat.emit_last = ((r_i + CW'(1)) == r_count);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/merge_sort_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_engine
// Batch sorter: collects up to DEPTH signed values, sorts them ascending by
// bottom-up merge sort over two ping-pong buffers, and streams them out.
// ----------------------------------------------------------------------------
// Values load at one per cycle; the set ends with a transaction whose last bit
// is set. Values beyond DEPTH are dropped and every result of that set carries
// overflow. Sorting takes ceil(log2(n)) passes; each merge step is a registered
// buffer read, then compare and write, and each pair of runs and each pass adds
// a setup step. Emission reads each element from the buffer, then loads it into
// the output register once that register is free. Input is held off from the
// last transaction of a set until the final result has been loaded into the
// output register; it waits there while the next set loads. No buffer clearing
// is needed after reset.
module merge_sort_engine #(
    parameter int unsigned DEPTH = mse_pkg::DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mse_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mse_pkg::t_out o_out_data
);

    mse_pkg::t_cmd  cmd;
    mse_pkg::t_stat stat;

    mse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    mse_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/mse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks of the merge sort engine, bound to the top level.
// ----------------------------------------------------------------------------
module mse_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input mse_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input mse_pkg::t_out o_out_data
);

    logic in_acc, out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    // accepting the end of a set closes the input
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.last |=> !o_in_ready)
        else $error("input open right after end of set");

    // only the final element of a set may wait while a new set loads
    a_wait_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> o_out_data.last_out)
        else $error("non-final result pending while loading");

    // overflow is the same on every result of one set
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !o_out_data.last_out |=>
            !o_out_valid || (o_out_data.overflow == $past(o_out_data.overflow)))
        else $error("overflow changed within a set");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
